[hw/rtl/sprite_camera_projection_macros.svh]
`ifndef SPRITE_CAMERA_PROJECTION_MACROS_SVH
`define SPRITE_CAMERA_PROJECTION_MACROS_SVH

// implication in the same cycle
`ifndef SYNTHESIS
`define SCP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sprite projection check failed");
`else
`define SCP_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif

// implication in the next cycle
`ifndef SYNTHESIS
`define SCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sprite projection check failed");
`else
`define SCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[hw/rtl/scp_pkg.sv]
package scp_pkg;

    localparam int SCR_W      = 12;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam int DIV1_NUM_W = 48;
    localparam int DIV1_DEN_W = 32;
    localparam int DIV1_Q_W   = 47;
    localparam int DIV2_NUM_W = 59;
    localparam int DIV2_DEN_W = 47;
    localparam int DIV2_Q_W   = 15;

    localparam logic [SCR_W-1:0] RST_SCREEN_WIDTH  = 12'd640;
    localparam logic [SCR_W-1:0] RST_SCREEN_HEIGHT = 12'd480;
    localparam logic signed [15:0] RST_VIEWER_X = 16'sd0;
    localparam logic signed [15:0] RST_VIEWER_Y = 16'sd0;
    localparam logic signed [15:0] RST_FACING_X = 16'sd16384;
    localparam logic signed [15:0] RST_FACING_Y = 16'sd0;
    localparam logic signed [15:0] RST_LENS_X   = 16'sd0;
    localparam logic signed [15:0] RST_LENS_Y   = 16'sd10813;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 4'd0,
        CFG_SCREEN_HEIGHT = 4'd1,
        CFG_VIEWER_X      = 4'd2,
        CFG_VIEWER_Y      = 4'd3,
        CFG_FACING_X      = 4'd4,
        CFG_FACING_Y      = 4'd5,
        CFG_LENS_X        = 4'd6,
        CFG_LENS_Y        = 4'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BEHIND = 2'd1,
        ST_DEGEN  = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [15:0] object_x;
        logic signed [15:0] object_y;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic signed [15:0] depth;
        logic [33:0]        squared_distance;
        logic signed [15:0] screen_column;
        logic [14:0]        sprite_height;
        logic [14:0]        sprite_width;
        logic [11:0]        first_row;
        logic [11:0]        last_row;
        logic [14:0]        first_column;
        logic signed [15:0] last_column;
    } out_item_t;

endpackage

[hw/rtl/scp_div.sv]
module scp_div #(
    parameter int NUM_W  = 48,
    parameter int DEN_W  = 32,
    parameter int Q_W    = 47,
    parameter int LANES  = 2,
    parameter int SIDE_W = 36
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [LANES-1:0][NUM_W-1:0]    in_num,
    input  logic [DEN_W-1:0]               in_den,
    input  logic [SIDE_W-1:0]              in_side,
    output logic                           out_valid,
    output logic [LANES-1:0][Q_W-1:0]      out_quo,
    output logic [LANES-1:0]               out_ovf,
    output logic [SIDE_W-1:0]              out_side
);

    localparam int HI_W  = NUM_W - Q_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [Q_W:0]                    v_reg;
    logic [DEN_W-1:0]                den_reg  [Q_W+1];
    logic [DEN_W-1:0]                den_next [Q_W+1];
    logic [SIDE_W-1:0]               side_reg  [Q_W+1];
    logic [SIDE_W-1:0]               side_next [Q_W+1];
    logic [LANES-1:0]                ovf_reg  [Q_W+1];
    logic [LANES-1:0]                ovf_next [Q_W+1];
    logic [LANES-1:0][DEN_W-1:0]     rem_reg  [Q_W+1];
    logic [LANES-1:0][DEN_W-1:0]     rem_next [Q_W+1];
    logic [LANES-1:0][Q_W-1:0]       low_reg  [Q_W+1];
    logic [LANES-1:0][Q_W-1:0]       low_next [Q_W+1];

    // stage 0 takes the high numerator part and flags overflow, then one quotient bit a stage
    always_comb begin
        logic [HI_W-1:0] hi;
        logic [DEN_W:0]  trial;
        logic            ge;
        den_next[0]  = in_den;
        side_next[0] = in_side;
        for (int l = 0; l < LANES; l++) begin
            hi                = in_num[l][NUM_W-1:Q_W];
            ovf_next[0][l]    = (CMP_W'(hi) >= CMP_W'(in_den));
            rem_next[0][l]    = DEN_W'(hi);
            low_next[0][l]    = in_num[l][Q_W-1:0];
        end
        for (int k = 1; k <= Q_W; k++) begin
            den_next[k]  = den_reg[k-1];
            side_next[k] = side_reg[k-1];
            ovf_next[k]  = ovf_reg[k-1];
            for (int l = 0; l < LANES; l++) begin
                trial = {rem_reg[k-1][l], low_reg[k-1][l][Q_W-1]};
                ge    = (trial >= {1'b0, den_reg[k-1]});
                rem_next[k][l] = ge ? DEN_W'(trial - {1'b0, den_reg[k-1]}) : DEN_W'(trial);
                low_next[k][l] = {low_reg[k-1][l][Q_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[Q_W-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k <= Q_W; k++) begin
                den_reg[k]  <= den_next[k];
                side_reg[k] <= side_next[k];
                ovf_reg[k]  <= ovf_next[k];
                rem_reg[k]  <= rem_next[k];
                low_reg[k]  <= low_next[k];
            end
        end
    end

    assign out_valid = v_reg[Q_W];
    assign out_quo   = low_reg[Q_W];
    assign out_ovf   = ovf_reg[Q_W];
    assign out_side  = side_reg[Q_W];

endmodule

[hw/rtl/sprite_camera_projection.sv]
// Sprite projection for a grid renderer.
// Input channel s_*: one item is a sprite world position (Q8.8). Result
// channel m_*: one item per input item, in order: status, depth, squared
// distance, centre column, sprite size and the clamped draw bounds.
// Configuration channel cfg_*: register index and data, always ready; an
// input item is held off in a cycle that carries a configuration write.
// Throughput: one item per cycle while no result waits unaccepted on m_*.
// The pipeline is built around two pipelined restoring dividers, an entry
// stage then one quotient bit per stage: 48 stages for the camera transform
// (shared determinant) and 16 stages for column, height and width over
// depth, plus the multiply, add and bound stages around them.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_ready drops; nothing is lost or repeated. Reset (aresetn low at a
// rising edge) clears all valid bits and loads the configuration defaults
// (640x480 screen, viewer at origin, facing +x, lens plane y 0.66).
`include "sprite_camera_projection_macros.svh"

module sprite_camera_projection
    import scp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SIDE1_W = 36;
    localparam int SIDE2_W = 52;

    logic [SCR_W-1:0]   scr_w_reg, scr_h_reg;
    logic signed [15:0] view_x_reg, view_y_reg, face_x_reg, face_y_reg, lens_x_reg, lens_y_reg;

    logic signed [31:0]    det_p1_reg, det_p2_reg;
    logic signed [32:0]    det_reg;
    logic [DIV1_DEN_W-1:0] det_mag_reg;
    logic                  det_neg_reg, det_zero_reg;

    logic en;
    logic s1_v_reg, s2_v_reg, s3_v_reg, s5_v_reg, s6_v_reg, s7_v_reg, s8_v_reg, out_v_reg;

    logic signed [16:0] rx_reg, ry_reg, rx_next, ry_next;
    logic signed [32:0] fyrx_reg, fxry_reg, lxry_reg, lyrx_reg;
    logic [32:0]        rx2_reg, ry2_reg;
    logic signed [33:0] nx_reg, ny_reg;
    logic [33:0]        sq_reg;

    logic [32:0]                            mag_x, mag_y;
    logic [1:0][DIV1_NUM_W-1:0]             d1_num;
    logic [DIV1_DEN_W-1:0]                  d1_den;
    logic [SIDE1_W-1:0]                     d1_side_in, d1_side_out;
    logic                                   d1_v;
    logic [1:0][DIV1_Q_W-1:0]               d1_quo;
    logic [1:0]                             d1_ovf;

    logic signed [47:0] tx_reg, ty_reg, tx_next, ty_next, ty6_reg, ty7_reg;
    logic signed [48:0] sum_reg;
    logic signed [60:0] colnum_reg;
    logic [33:0]        sq5_reg, sq6_reg, sq7_reg;

    logic                         col_neg, ty_pos;
    logic signed [15:0]           depth_next;
    logic [2:0][DIV2_NUM_W-1:0]   d2_num;
    logic [DIV2_DEN_W-1:0]        d2_den;
    logic [SIDE2_W-1:0]           d2_side_in, d2_side_out;
    logic                         d2_v;
    logic [2:0][DIV2_Q_W-1:0]     d2_quo;
    logic [2:0]                   d2_ovf;

    logic [33:0]        sq_d2;
    logic signed [15:0] depth_d2;
    logic               typos_d2, colneg_d2;

    logic signed [15:0] col_next, col8_reg, depth8_reg;
    logic [14:0]        sh_next, sw_next, sh8_reg, sw8_reg;
    logic [33:0]        sq8_reg;
    logic               typos8_reg;

    logic signed [15:0] r0v;
    logic [14:0]        r1v;
    logic signed [16:0] c0v, c1v, w_s;
    out_item_t          out_reg, out_next;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scr_w_reg  <= RST_SCREEN_WIDTH;
            scr_h_reg  <= RST_SCREEN_HEIGHT;
            view_x_reg <= RST_VIEWER_X;
            view_y_reg <= RST_VIEWER_Y;
            face_x_reg <= RST_FACING_X;
            face_y_reg <= RST_FACING_Y;
            lens_x_reg <= RST_LENS_X;
            lens_y_reg <= RST_LENS_Y;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SCREEN_WIDTH: begin
                    scr_w_reg <= cfg_data[SCR_W-1:0];
                end
                CFG_SCREEN_HEIGHT: begin
                    scr_h_reg <= cfg_data[SCR_W-1:0];
                end
                CFG_VIEWER_X: begin
                    view_x_reg <= signed'(cfg_data);
                end
                CFG_VIEWER_Y: begin
                    view_y_reg <= signed'(cfg_data);
                end
                CFG_FACING_X: begin
                    face_x_reg <= signed'(cfg_data);
                end
                CFG_FACING_Y: begin
                    face_y_reg <= signed'(cfg_data);
                end
                CFG_LENS_X: begin
                    lens_x_reg <= signed'(cfg_data);
                end
                CFG_LENS_Y: begin
                    lens_y_reg <= signed'(cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    // camera determinant, follows the registers
    always_ff @(posedge aclk) begin
        det_p1_reg   <= lens_x_reg * face_y_reg;
        det_p2_reg   <= face_x_reg * lens_y_reg;
        det_reg      <= 33'(det_p1_reg) - 33'(det_p2_reg);
        det_neg_reg  <= det_reg[32];
        det_zero_reg <= (det_reg == '0);
        det_mag_reg  <= det_reg[32] ? DIV1_DEN_W'(-det_reg) : DIV1_DEN_W'(det_reg);
    end

    // pipeline control
    assign en      = m_ready || !out_v_reg;
    assign s_ready = en && !cfg_valid;
    assign m_valid = out_v_reg;
    assign m_item  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            s6_v_reg  <= 1'b0;
            s7_v_reg  <= 1'b0;
            s8_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            s1_v_reg  <= s_valid && !cfg_valid;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s5_v_reg  <= d1_v;
            s6_v_reg  <= s5_v_reg;
            s7_v_reg  <= s6_v_reg;
            s8_v_reg  <= d2_v;
            out_v_reg <= s8_v_reg;
        end
    end

    // relative position and camera transform numerators
    assign rx_next = 17'(s_item.object_x) - 17'(view_x_reg);
    assign ry_next = 17'(s_item.object_y) - 17'(view_y_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            fyrx_reg <= face_y_reg * rx_reg;
            fxry_reg <= face_x_reg * ry_reg;
            lxry_reg <= lens_x_reg * ry_reg;
            lyrx_reg <= lens_y_reg * rx_reg;
            rx2_reg  <= rx_reg * rx_reg;
            ry2_reg  <= ry_reg * ry_reg;
            nx_reg   <= 34'(fyrx_reg) - 34'(fxry_reg);
            ny_reg   <= 34'(lxry_reg) - 34'(lyrx_reg);
            sq_reg   <= 34'(rx2_reg) + 34'(ry2_reg);
        end
    end

    always_comb begin
        mag_x      = nx_reg[33] ? 33'(-nx_reg) : nx_reg[32:0];
        mag_y      = ny_reg[33] ? 33'(-ny_reg) : ny_reg[32:0];
        d1_num[0]  = {1'b0, mag_x, 14'd0};
        d1_num[1]  = {1'b0, mag_y, 14'd0};
        d1_den     = det_zero_reg ? DIV1_DEN_W'(1) : det_mag_reg;
        d1_side_in = {sq_reg, nx_reg[33] ^ det_neg_reg, ny_reg[33] ^ det_neg_reg};
    end

    scp_div #(
        .NUM_W  (DIV1_NUM_W),
        .DEN_W  (DIV1_DEN_W),
        .Q_W    (DIV1_Q_W),
        .LANES  (2),
        .SIDE_W (SIDE1_W)
    ) u_div_cam (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s3_v_reg),
        .in_num    (d1_num),
        .in_den    (d1_den),
        .in_side   (d1_side_in),
        .out_valid (d1_v),
        .out_quo   (d1_quo),
        .out_ovf   (d1_ovf),
        .out_side  (d1_side_out)
    );

    // signed camera coordinates, column numerator
    always_comb begin
        tx_next = d1_side_out[1] ? -signed'({1'b0, d1_quo[0]}) : signed'({1'b0, d1_quo[0]});
        ty_next = d1_side_out[0] ? -signed'({1'b0, d1_quo[1]}) : signed'({1'b0, d1_quo[1]});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tx_reg     <= tx_next;
            ty_reg     <= ty_next;
            sq5_reg    <= d1_side_out[SIDE1_W-1:2];
            sum_reg    <= 49'(tx_reg) + 49'(ty_reg);
            ty6_reg    <= ty_reg;
            sq6_reg    <= sq5_reg;
            colnum_reg <= signed'({1'b0, scr_w_reg[SCR_W-1:1]}) * sum_reg;
            ty7_reg    <= ty6_reg;
            sq7_reg    <= sq6_reg;
        end
    end

    always_comb begin
        col_neg = colnum_reg[60];
        ty_pos  = !ty7_reg[47] && (ty7_reg != '0);
        if (ty7_reg > 48'sd32767) begin
            depth_next = 16'sh7fff;
        end else if (ty7_reg < -48'sd32768) begin
            depth_next = 16'sh8000;
        end else begin
            depth_next = ty7_reg[15:0];
        end
        d2_num[0]  = col_neg ? DIV2_NUM_W'(-colnum_reg) : colnum_reg[DIV2_NUM_W-1:0];
        d2_num[1]  = DIV2_NUM_W'({scr_h_reg, 8'd0});
        d2_num[2]  = DIV2_NUM_W'({scr_w_reg, 8'd0});
        d2_den     = ty_pos ? ty7_reg[DIV2_DEN_W-1:0] : DIV2_DEN_W'(1);
        d2_side_in = {sq7_reg, depth_next, ty_pos, col_neg};
    end

    scp_div #(
        .NUM_W  (DIV2_NUM_W),
        .DEN_W  (DIV2_DEN_W),
        .Q_W    (DIV2_Q_W),
        .LANES  (3),
        .SIDE_W (SIDE2_W)
    ) u_div_scr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s7_v_reg),
        .in_num    (d2_num),
        .in_den    (d2_den),
        .in_side   (d2_side_in),
        .out_valid (d2_v),
        .out_quo   (d2_quo),
        .out_ovf   (d2_ovf),
        .out_side  (d2_side_out)
    );

    // saturation of column, height and width
    always_comb begin
        {sq_d2, depth_d2, typos_d2, colneg_d2} = d2_side_out;
        if (!colneg_d2) begin
            col_next = d2_ovf[0] ? 16'sh7fff : signed'({1'b0, d2_quo[0]});
        end else begin
            col_next = d2_ovf[0] ? 16'sh8000 : -signed'({1'b0, d2_quo[0]});
        end
        sh_next = d2_ovf[1] ? 15'h7fff : d2_quo[1];
        sw_next = d2_ovf[2] ? 15'h7fff : d2_quo[2];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            col8_reg   <= col_next;
            sh8_reg    <= sh_next;
            sw8_reg    <= sw_next;
            sq8_reg    <= sq_d2;
            depth8_reg <= depth_d2;
            typos8_reg <= typos_d2;
            out_reg    <= out_next;
        end
    end

    // draw bounds and status
    always_comb begin
        r0v = 16'(scr_h_reg[SCR_W-1:1]) - 16'(sh8_reg[14:1]);
        r1v = 15'(sh8_reg[14:1]) + 15'(scr_h_reg[SCR_W-1:1]);
        c0v = 17'(col8_reg) - 17'(sw8_reg[14:1]);
        c1v = 17'(col8_reg) + 17'(sw8_reg[14:1]);
        w_s = signed'({5'd0, scr_w_reg});

        out_next                  = '0;
        out_next.squared_distance = sq8_reg;
        if (det_zero_reg) begin
            out_next.status = ST_DEGEN;
        end else if (!typos8_reg) begin
            out_next.status = ST_BEHIND;
            out_next.depth  = depth8_reg;
        end else begin
            out_next.status        = ST_OK;
            out_next.depth         = depth8_reg;
            out_next.screen_column = col8_reg;
            out_next.sprite_height = sh8_reg;
            out_next.sprite_width  = sw8_reg;
            out_next.first_row     = r0v[15] ? 12'd0 : r0v[11:0];
            if (r1v >= 15'(scr_h_reg)) begin
                out_next.last_row = (scr_h_reg == '0) ? 12'd0 : scr_h_reg - 12'd1;
            end else begin
                out_next.last_row = r1v[11:0];
            end
            out_next.first_column = c0v[16] ? 15'd0 : c0v[14:0];
            if (c1v >= w_s) begin
                out_next.last_column = 16'(w_s - 17'sd1);
            end else begin
                out_next.last_column = c1v[15:0];
            end
        end
    end

    `SCP_ASSERT_IMPL(a_stall_blocks_input, aclk, aresetn, m_valid && !m_ready, !s_ready)
    `SCP_ASSERT_NEXT(a_cfg_write_holds_item, aclk, aresetn, cfg_valid && en, !s1_v_reg)
    `SCP_ASSERT_IMPL(a_cam_quotient_fits, aclk, aresetn, d1_v, d1_ovf == '0)
    `SCP_ASSERT_IMPL(a_degen_zeroed, aclk, aresetn, m_valid && (m_item.status == ST_DEGEN), (m_item.depth == '0) && (m_item.last_column == '0))
    `SCP_ASSERT_IMPL(a_ok_depth_positive, aclk, aresetn, m_valid && (m_item.status == ST_OK), !m_item.depth[15] && (m_item.depth != '0))
    `SCP_ASSERT_IMPL(a_behind_zeroed, aclk, aresetn, m_valid && (m_item.status == ST_BEHIND), (m_item.screen_column == '0) && (m_item.sprite_width == '0))

endmodule
